// ===== rtl/pip_pkg.sv =====
// Package for the polygon point inside test: widths, step codes and shared types.
package pip_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int WINDING_WIDTH = 16;
  localparam int OFF_WIDTH     = COORD_WIDTH + 1;
  localparam int PROD_WIDTH    = 2 * OFF_WIDTH;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int INSIDE_LIMIT  = 4;
  localparam int SHORT_COUNT   = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_TEST_X   = 2'd0,
    REG_TEST_Y   = 2'd1,
    REG_BOUNDARY = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_TWO  = 2'd2,
    STEP_BACK = 2'd3
  } step_t;

  typedef struct packed {
    step_t step;
    logic  cross_neg;
    logic  cross_zero;
    logic  zero_off;
    logic  last;
    logic  short_path;
  } cmd_t;

  typedef struct packed {
    logic a_vld;
    logic b_vld;
  } front_stat_t;

endpackage

// ===== rtl/pip_front.sv =====
// Front end: offsets, quadrant steps and the cross product of each vertex.
module pip_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0]  vertex_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0]  vertex_y,
  input  logic                                    last_vertex,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0]  test_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0]  test_y,
  input  logic                                    q_full,
  output logic                                    q_wr,
  output pip_pkg::cmd_t                           q_data,
  output pip_pkg::front_stat_t                    stat
);

  localparam int OW = pip_pkg::OFF_WIDTH;
  localparam int PW = pip_pkg::PROD_WIDTH;

  logic signed [OW-1:0] off_x;
  logic signed [OW-1:0] off_y;
  logic                 off_zero;
  logic [1:0]           quad;
  logic [1:0]           quad_diff;
  pip_pkg::step_t       step;
  logic                 accept;
  logic                 a_ready;
  logic                 b_ready;

  logic [1:0]           count;
  logic [1:0]           prev_quad;
  logic signed [OW-1:0] prev_x;
  logic signed [OW-1:0] prev_y;

  logic                 a_vld;
  logic signed [OW-1:0] a_ox;
  logic signed [OW-1:0] a_oy;
  logic signed [OW-1:0] a_px;
  logic signed [OW-1:0] a_py;
  pip_pkg::step_t       a_step;
  logic                 a_zero;
  logic                 a_last;
  logic                 a_short;

  logic                 b_vld;
  logic signed [PW-1:0] b_p;
  logic signed [PW-1:0] b_q;
  pip_pkg::step_t       b_step;
  logic                 b_zero;
  logic                 b_last;
  logic                 b_short;
  logic signed [PW:0]   cross_val;

  assign off_x    = $signed({vertex_x[pip_pkg::COORD_WIDTH-1], vertex_x})
                  - $signed({test_x[pip_pkg::COORD_WIDTH-1], test_x});
  assign off_y    = $signed({vertex_y[pip_pkg::COORD_WIDTH-1], vertex_y})
                  - $signed({test_y[pip_pkg::COORD_WIDTH-1], test_y});
  assign off_zero = (off_x == '0) && (off_y == '0);

  always_comb begin
    if (!off_x[OW-1] && off_y[OW-1]) begin
      quad = 2'd0;
    end else if (!off_x[OW-1] && (off_x != '0) && !off_y[OW-1]) begin
      quad = 2'd1;
    end else if ((off_x[OW-1] || (off_x == '0)) && !off_y[OW-1] && (off_y != '0)) begin
      quad = 2'd2;
    end else begin
      quad = 2'd3;
    end
  end

  assign quad_diff = quad - prev_quad;

  always_comb begin
    if (count == 2'd0) begin
      step = pip_pkg::STEP_NONE;
    end else begin
      case (quad_diff)
        2'd1:    step = pip_pkg::STEP_FWD;
        2'd2:    step = pip_pkg::STEP_TWO;
        2'd3:    step = pip_pkg::STEP_BACK;
        default: step = pip_pkg::STEP_NONE;
      endcase
    end
  end

  assign b_ready  = !b_vld || !q_full;
  assign a_ready  = !a_vld || b_ready;
  assign in_stall = !a_ready;
  assign accept   = in_valid && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      count     <= 2'd0;
      prev_quad <= 2'd0;
    end else begin
      if (a_ready) begin
        a_vld <= in_valid;
      end
      if (b_ready) begin
        b_vld <= a_vld;
      end
      if (accept) begin
        if (last_vertex) begin
          count     <= 2'd0;
          prev_quad <= 2'd0;
        end else begin
          if (count != 2'd3) begin
            count <= count + 2'd1;
          end
          if (!off_zero) begin
            prev_quad <= quad;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ox    <= off_x;
      a_oy    <= off_y;
      a_px    <= prev_x;
      a_py    <= prev_y;
      a_step  <= step;
      a_zero  <= off_zero;
      a_last  <= last_vertex;
      a_short <= count < 2'(pip_pkg::SHORT_COUNT);
      if (!off_zero) begin
        prev_x <= off_x;
        prev_y <= off_y;
      end
    end
    if (b_ready && a_vld) begin
      b_p     <= PW'(a_py) * PW'(a_ox);
      b_q     <= PW'(a_px) * PW'(a_oy);
      b_step  <= a_step;
      b_zero  <= a_zero;
      b_last  <= a_last;
      b_short <= a_short;
    end
  end

  assign cross_val = $signed({b_p[PW-1], b_p}) - $signed({b_q[PW-1], b_q});

  assign q_wr              = b_vld && !q_full;
  assign q_data.step       = b_step;
  assign q_data.cross_neg  = cross_val[PW];
  assign q_data.cross_zero = (cross_val == '0);
  assign q_data.zero_off   = b_zero;
  assign q_data.last       = b_last;
  assign q_data.short_path = b_short;

  assign stat.a_vld = a_vld;
  assign stat.b_vld = b_vld;

endmodule

// ===== rtl/pip_queue.sv =====
// Short queue of classified vertex commands between the front and back ends.
module pip_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pip_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output pip_pkg::cmd_t rd_data
);

  localparam int DEPTH = pip_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pip_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/pip_back.sv =====
// Back end: winding accumulation, edge tracking and the result register.
module pip_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  pip_pkg::cmd_t q_data,
  output logic          q_pop,
  input  logic          boundary_result,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          inside_res,
  output logic          on_edge
);

  localparam int WW = pip_pkg::WINDING_WIDTH;
  localparam logic signed [WW:0]   W_MAX  = {2'b00, {(WW-1){1'b1}}};
  localparam logic signed [WW:0]   W_MIN  = {2'b11, {(WW-1){1'b0}}};
  localparam logic signed [WW-1:0] W_FOUR = WW'(pip_pkg::INSIDE_LIMIT);

  logic signed [WW-1:0] winding;
  logic                 edge_hit;
  logic signed [2:0]    delta;
  logic signed [WW:0]   sum;
  logic signed [WW-1:0] winding_next;
  logic                 edge_next;
  logic                 is_inside;

  always_comb begin
    delta     = 3'sd0;
    edge_next = edge_hit;
    if (!edge_hit) begin
      if (q_data.zero_off) begin
        edge_next = 1'b1;
      end else begin
        case (q_data.step)
          pip_pkg::STEP_FWD:  delta = 3'sd1;
          pip_pkg::STEP_BACK: delta = -3'sd1;
          pip_pkg::STEP_TWO: begin
            if (q_data.cross_zero) begin
              edge_next = 1'b1;
            end else if (q_data.cross_neg) begin
              delta = 3'sd2;
            end else begin
              delta = -3'sd2;
            end
          end
          default: delta = 3'sd0;
        endcase
      end
    end
    sum = $signed({winding[WW-1], winding}) + (WW+1)'(delta);
    if (sum > W_MAX) begin
      winding_next = W_MAX[WW-1:0];
    end else if (sum < W_MIN) begin
      winding_next = W_MIN[WW-1:0];
    end else begin
      winding_next = sum[WW-1:0];
    end
    is_inside = (winding_next >= W_FOUR) || (winding_next <= -W_FOUR);
  end

  assign q_pop = q_valid && (!q_data.last || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      winding   <= '0;
      edge_hit  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_data.last) begin
          out_valid <= 1'b1;
          winding   <= '0;
          edge_hit  <= 1'b0;
        end else begin
          winding   <= winding_next;
          edge_hit  <= edge_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      if (q_data.short_path) begin
        inside_res <= 1'b0;
        on_edge    <= 1'b0;
      end else if (edge_next) begin
        inside_res <= boundary_result;
        on_edge    <= 1'b1;
      end else begin
        inside_res <= is_inside;
        on_edge    <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/polygon_point_inside_test_top.sv =====
// Top level of the polygon point inside test by quadrant winding.
//
//   Channel  Handshake              Payload
//   vertex   in_valid / in_stall    vertex_x, vertex_y, last_vertex
//   result   out_valid / out_stall  inside_res, on_edge
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One vertex is accepted per cycle while in_stall is low; the rate is set by
// the front pipeline (offset stage, then a registered multiplier stage)
// feeding a two-entry queue. A path's result is registered in the back end
// when its last vertex is popped from the queue. Reset clears the pipeline,
// the queue and the path state and sets the registers to their reset values.
// A stalled result holds the back end only when a further last vertex arrives;
// the queue then fills and in_stall rises. cfg_ready is always high.
module polygon_point_inside_test_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0]  vertex_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0]  vertex_y,
  input  logic                                    last_vertex,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    inside_res,
  output logic                                    on_edge,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pip_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
  input  logic [pip_pkg::COORD_WIDTH-1:0]         cfg_data
);

  logic signed [pip_pkg::COORD_WIDTH-1:0] test_x;
  logic signed [pip_pkg::COORD_WIDTH-1:0] test_y;
  logic                                   boundary_result;

  logic                 q_wr;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  pip_pkg::cmd_t        q_wr_data;
  pip_pkg::cmd_t        q_rd_data;
  pip_pkg::front_stat_t front_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_x          <= '0;
      test_y          <= '0;
      boundary_result <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pip_pkg::REG_TEST_X:   test_x          <= cfg_data;
        pip_pkg::REG_TEST_Y:   test_y          <= cfg_data;
        pip_pkg::REG_BOUNDARY: boundary_result <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pip_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .test_x      (test_x),
    .test_y      (test_y),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_data      (q_wr_data),
    .stat        (front_stat)
  );

  pip_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  pip_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .boundary_result (boundary_result),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .inside_res      (inside_res),
    .on_edge         (on_edge)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_full |-> !q_wr)
    else $error("Queue written while full.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (front_stat.a_vld && front_stat.b_vld && q_full))
    else $error("Vertex stalled while the front pipeline had room.");

  a_back_holds_only_on_result: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop) |-> (out_valid && out_stall && q_rd_data.last))
    else $error("Back end held a transaction without a pending result.");

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule
